@@ rtl/crtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crtc_pkg;

   localparam int unsigned NUM_REGISTERS = 18;
   localparam int unsigned IDX_W = 5;

   localparam logic [IDX_W-1:0] REG_HTOTAL      = 5'd0;
   localparam logic [IDX_W-1:0] REG_HDISP       = 5'd1;
   localparam logic [IDX_W-1:0] REG_HSYNC_POS   = 5'd2;
   localparam logic [IDX_W-1:0] REG_HSYNC_WIDTH = 5'd3;
   localparam logic [IDX_W-1:0] REG_VTOTAL      = 5'd4;
   localparam logic [IDX_W-1:0] REG_VDISP       = 5'd6;
   localparam logic [IDX_W-1:0] REG_MAX_SCAN    = 5'd9;
   localparam logic [IDX_W-1:0] REG_START_HI    = 5'd12;
   localparam logic [IDX_W-1:0] REG_START_LO    = 5'd13;
   localparam logic [IDX_W-1:0] REG_CURSOR_HI   = 5'd14;
   localparam logic [IDX_W-1:0] REG_CURSOR_LO   = 5'd15;

   localparam logic [7:0] STATUS_TOGGLE = 8'h09;
   localparam logic [7:0] VIDEO_ENABLE  = 8'h09;

   typedef enum logic [2:0] {
      OP_WR_INDEX = 3'd0,
      OP_WR_DATA  = 3'd1,
      OP_RD_DATA  = 3'd2,
      OP_WR_CTRL  = 3'd3,
      OP_RD_CTRL  = 3'd4,
      OP_RD_STAT  = 3'd5,
      OP_TICK     = 3'd6
   } op_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] write_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [15:0] cursor_address;
      logic [15:0] start_address;
      logic        primed_flag;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/crtc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface crtc_req_if;
   logic             valid;
   logic             ready;
   crtc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface crtc_rsp_if;
   logic             valid;
   logic             ready;
   crtc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface crtc_csr_if;
   logic valid;
   logic ready;
   logic mono_mode;
   modport source (output valid, output mono_mode, input ready);
   modport sink   (input valid, input mono_mode, output ready);
endinterface

`default_nettype wire

@@ rtl/crtc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crtc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire crtc_pkg::req_type req,
   input  wire logic              csr_write,
   input  wire logic              csr_mono,
   output crtc_pkg::rsp_type      rsp
);

   logic [7:0] regs_ff [crtc_pkg::NUM_REGISTERS];
   logic [7:0] regs_in [crtc_pkg::NUM_REGISTERS];
   logic [crtc_pkg::IDX_W-1:0] index_ff, index_in;
   logic [7:0] mode_ff, mode_in;
   logic       primed_ff, primed_in;
   logic       mono_ff;
   logic [7:0] char_ff, char_in;
   logic [7:0] scan_ff, scan_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] status_ff, status_in;

   logic [7:0] r_htot, r_hdisp, r_hs_pos, r_hs_wid, r_vtot, r_vdisp, r_maxscan;
   logic [7:0] adv_char, adv_scan, adv_row, char_inc, scan_inc, row_inc;
   logic       wrap_c, wrap_s, wrap_r;
   logic       in_win, hs, vid;
   logic [8:0] hs_end;
   logic [7:0] stat_val, rd, idx_val;
   logic       idx_ok;

   assign r_htot    = regs_ff[crtc_pkg::REG_HTOTAL];
   assign r_hdisp   = regs_ff[crtc_pkg::REG_HDISP];
   assign r_hs_pos  = regs_ff[crtc_pkg::REG_HSYNC_POS];
   assign r_hs_wid  = regs_ff[crtc_pkg::REG_HSYNC_WIDTH];
   assign r_vtot    = regs_ff[crtc_pkg::REG_VTOTAL];
   assign r_vdisp   = regs_ff[crtc_pkg::REG_VDISP];
   assign r_maxscan = regs_ff[crtc_pkg::REG_MAX_SCAN];

   assign idx_ok  = (index_ff < crtc_pkg::IDX_W'(crtc_pkg::NUM_REGISTERS));
   assign idx_val = idx_ok ? regs_ff[index_ff] : 8'd0;

   // one character clock
   always_comb begin
      char_inc = char_ff + 8'd1;
      scan_inc = scan_ff + 8'd1;
      row_inc  = row_ff + 8'd1;
      wrap_c   = (r_htot != 8'd0) && (char_inc > r_htot);
      wrap_s   = (r_maxscan != 8'd0) && (scan_inc > r_maxscan);
      wrap_r   = (r_vtot != 8'd0) && (row_inc > r_vtot);
      adv_char = char_inc;
      adv_scan = scan_ff;
      adv_row  = row_ff;
      if (wrap_c) begin
         adv_char = 8'd0;
         adv_scan = scan_inc;
         if (wrap_s) begin
            adv_scan = 8'd0;
            adv_row  = wrap_r ? 8'd0 : row_inc;
         end
      end
   end

   // status bits from the advanced position
   always_comb begin
      in_win = (adv_char < r_hdisp) && (adv_row < r_vdisp);
      hs_end = {1'b0, r_hs_pos} + {1'b0, r_hs_wid};
      hs     = 1'b0;
      vid    = 1'b0;
      if (mono_ff) begin
         if (r_hs_pos != 8'd0) begin
            hs = (adv_char >= r_hs_pos) && ({1'b0, adv_char} < hs_end);
         end else begin
            hs = (adv_char[1:0] < 2'd2);
         end
         vid = ((mode_ff & crtc_pkg::VIDEO_ENABLE) == crtc_pkg::VIDEO_ENABLE) && in_win;
      end else begin
         hs = !in_win;
         if (r_vdisp != 8'd0) begin
            vid = (adv_row >= r_vdisp);
         end else begin
            vid = (adv_char[2:0] < 3'd5);
         end
      end
      if (r_htot == 8'd0) begin
         stat_val = status_ff ^ crtc_pkg::STATUS_TOGGLE;
      end else begin
         stat_val = {4'd0, vid, 2'd0, hs};
      end
   end

   always_comb begin
      regs_in   = regs_ff;
      index_in  = index_ff;
      mode_in   = mode_ff;
      primed_in = primed_ff;
      char_in   = char_ff;
      scan_in   = scan_ff;
      row_in    = row_ff;
      status_in = status_ff;
      rd        = 8'd0;
      unique case (req.op)
         crtc_pkg::OP_WR_INDEX: begin
            index_in = req.write_value[crtc_pkg::IDX_W-1:0];
         end
         crtc_pkg::OP_WR_DATA: begin
            if (idx_ok) begin
               regs_in[index_ff] = req.write_value;
            end
         end
         crtc_pkg::OP_RD_DATA: begin
            rd = idx_val;
         end
         crtc_pkg::OP_WR_CTRL: begin
            mode_in = req.write_value;
            if (mono_ff && req.write_value[0]) begin
               primed_in = 1'b1;
            end
         end
         crtc_pkg::OP_RD_CTRL: begin
            rd = mode_ff;
         end
         crtc_pkg::OP_RD_STAT: begin
            char_in   = adv_char;
            scan_in   = adv_scan;
            row_in    = adv_row;
            status_in = stat_val;
            rd        = stat_val;
         end
         crtc_pkg::OP_TICK: begin
            char_in = adv_char;
            scan_in = adv_scan;
            row_in  = adv_row;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.read_value     = rd;
      rsp.cursor_address = {regs_in[crtc_pkg::REG_CURSOR_HI], regs_in[crtc_pkg::REG_CURSOR_LO]};
      rsp.start_address  = {regs_in[crtc_pkg::REG_START_HI], regs_in[crtc_pkg::REG_START_LO]};
      rsp.primed_flag    = primed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crtc_pkg::NUM_REGISTERS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         index_ff  <= '0;
         mode_ff   <= 8'd0;
         primed_ff <= 1'b0;
         mono_ff   <= 1'b0;
         char_ff   <= 8'd0;
         scan_ff   <= 8'd0;
         row_ff    <= 8'd0;
         status_ff <= 8'd0;
      end else begin
         if (csr_write) begin
            mono_ff <= csr_mono;
         end
         if (step) begin
            regs_ff   <= regs_in;
            index_ff  <= index_in;
            mode_ff   <= mode_in;
            primed_ff <= primed_in;
            char_ff   <= char_in;
            scan_ff   <= scan_in;
            row_ff    <= row_in;
            status_ff <= status_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff) else $error("primed flag cleared");
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(char_ff) && $stable(index_ff) && $stable(status_ff))
      else $error("state moved without an item");
   a_status_bits: assert property (@(posedge clock) disable iff (reset)
      (step && req.op == crtc_pkg::OP_RD_STAT && r_htot != 8'd0)
      |=> (status_ff[7:4] == 4'd0 && status_ff[2:1] == 2'd0))
      else $error("status byte has stray bits");
`endif

endmodule

`default_nettype wire

@@ rtl/crtc_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crtc_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire crtc_pkg::rsp_type push_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output crtc_pkg::rsp_type      out_data,
   input  wire logic              out_ready
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   crtc_pkg::rsp_type main_data_ff, main_data_in;
   crtc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff) else $error("skid full with empty head");
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !out_ready |=> main_valid_ff && $stable(main_data_ff))
      else $error("waiting item lost");
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      push && main_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("item dropped while head waits");
`endif

endmodule

`default_nettype wire

@@ rtl/crt_controller_status_timing.sv @@
`timescale 1ns / 1ps
`default_nettype none

// CRT controller with status port. Each request item is one bus access (index, data
// or control read/write, status read) or one character-clock tick, and yields exactly
// one response item carrying the read byte plus the current cursor and start addresses
// and the primed flag, all as they stand after the access. Throughput is one item per
// clock while rsp ready is high; each response is registered in the output
// buffer before rsp valid. A two-entry response buffer keeps req ready high while one
// response waits, so req ready only drops once two responses are pending. csr ready
// is always high; write mono_mode only while no items are in flight.
module crt_controller_status_timing (
   input wire logic   clock,
   input wire logic   reset,
   crtc_req_if.sink   req_chan,
   crtc_rsp_if.source rsp_chan,
   crtc_csr_if.sink   csr_chan
);

   logic              step;
   crtc_pkg::rsp_type core_rsp;

   assign step           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   crtc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_chan.data),
      .csr_write (csr_chan.valid),
      .csr_mono  (csr_chan.mono_mode),
      .rsp       (core_rsp)
   );

   crtc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (core_rsp),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_chan.data),
      .out_ready (rsp_chan.ready)
   );

endmodule

`default_nettype wire
